### sv/ihf_pkg.sv
// Package for the IPv4 header fragmenter: field widths, header constants,
// register map and the packet descriptor that the front hands to the back.
// No dependencies.
`default_nettype none

package ihf_pkg;

    localparam int PLEN_W  = 16;
    localparam int ADDR_W  = 32;
    localparam int PROTO_W = 8;
    localparam int LEN_W   = 14;
    localparam int ID_W    = 16;
    localparam int FO_W    = 14;
    localparam int CSUM_W  = 16;

    localparam logic [15:0]      VER_IHL_WORD = 16'h4500;
    localparam logic [7:0]       TTL_VAL      = 8'd64;
    localparam logic [LEN_W-1:0] HDR_BYTES    = 14'd20;
    localparam logic [LEN_W-1:0] MTU_FLOOR    = 14'd1068;
    localparam logic [LEN_W-1:0] MTU_CEIL     = 14'd9216;
    localparam logic [LEN_W-1:0] MTU_RESET    = 14'd1500;
    localparam logic [ADDR_W-1:0] SRC_RESET   = 32'hC0A8_6450;
    localparam int FRAG_UNIT_LOG2 = 3;

    // APB register map: register i at byte address 4*i
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_LINK_MTU = 1'b0;
    localparam logic [0:0] REG_SRC_ADDR = 1'b1;

    // descriptor queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [PLEN_W-1:0]  payload_length;
        logic [ADDR_W-1:0]  dst;
        logic [PROTO_W-1:0] proto;
        logic [ID_W-1:0]    ident;
        logic [LEN_W-1:0]   chunk;      // bytes per full fragment
        logic [CSUM_W-1:0]  csum_base;  // folded sum of the fixed header words
    } t_pkt_desc;

endpackage

`default_nettype wire

### sv/ihf_if.sv
// Valid/ready channel interfaces for packet items and fragment descriptor items.
// Depends on ihf_pkg.
`default_nettype none

interface ihf_in_if;
    logic                         valid;
    logic                         ready;
    logic [ihf_pkg::PLEN_W-1:0]   payload_length;
    logic [ihf_pkg::ADDR_W-1:0]   destination_address;
    logic [ihf_pkg::PROTO_W-1:0]  protocol_number;

    modport source (output valid, payload_length, destination_address, protocol_number,
                    input ready);
    modport sink   (input valid, payload_length, destination_address, protocol_number,
                    output ready);
endinterface

interface ihf_out_if;
    logic                         valid;
    logic                         ready;
    logic [ihf_pkg::LEN_W-1:0]    datagram_length;
    logic [ihf_pkg::ID_W-1:0]     identification;
    logic [ihf_pkg::FO_W-1:0]     flags_and_offset;
    logic [ihf_pkg::CSUM_W-1:0]   header_checksum;
    logic [ihf_pkg::ADDR_W-1:0]   dest_out;
    logic [ihf_pkg::PROTO_W-1:0]  protocol_out;
    logic [ihf_pkg::PLEN_W-1:0]   payload_offset;
    logic [ihf_pkg::LEN_W-1:0]    fragment_length;
    logic                         last_fragment;

    modport source (output valid, datagram_length, identification, flags_and_offset,
                           header_checksum, dest_out, protocol_out, payload_offset,
                           fragment_length, last_fragment,
                    input ready);
    modport sink   (input valid, datagram_length, identification, flags_and_offset,
                          header_checksum, dest_out, protocol_out, payload_offset,
                          fragment_length, last_fragment,
                    output ready);
endinterface

`default_nettype wire

### sv/ihf_front.sv
// Front end: accepts packet items, assigns identification, clamps the MTU,
// works out the fragment size and the fixed part of the checksum. Uses ihf_pkg.
`default_nettype none

module ihf_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    ihf_in_if.sink                         i_pkt,
    input  wire logic [ihf_pkg::LEN_W-1:0]  i_link_mtu,
    input  wire logic [ihf_pkg::ADDR_W-1:0] i_src_addr,
    input  wire logic                      i_q_full,
    output logic                           o_push,
    output ihf_pkg::t_pkt_desc             o_push_data
);

    logic                          r_hold_vld;
    logic [ihf_pkg::PLEN_W-1:0]    r_plen;
    logic [ihf_pkg::ADDR_W-1:0]    r_dst;
    logic [ihf_pkg::PROTO_W-1:0]   r_proto;
    logic [ihf_pkg::ID_W-1:0]      r_ident;
    logic [ihf_pkg::ID_W-1:0]      r_next_id;

    logic                          accept;
    logic [ihf_pkg::LEN_W-1:0]     mtu_c;
    logic [ihf_pkg::LEN_W-1:0]     maxpay;
    logic                          fits;
    logic [18:0]                   base_sum;
    logic [16:0]                   base_f1;
    logic [15:0]                   base_f2;

    assign o_push      = r_hold_vld && !i_q_full;
    assign i_pkt.ready = !r_hold_vld || !i_q_full;
    assign accept      = i_pkt.valid && i_pkt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_next_id  <= '0;
        end else begin
            if (accept) begin
                r_hold_vld <= 1'b1;
                r_next_id  <= r_next_id + 16'd1;
            end else if (o_push) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_plen  <= i_pkt.payload_length;
            r_dst   <= i_pkt.destination_address;
            r_proto <= i_pkt.protocol_number;
            r_ident <= r_next_id;
        end
    end

    always_comb begin
        if (i_link_mtu < ihf_pkg::MTU_FLOOR) begin
            mtu_c = ihf_pkg::MTU_FLOOR;
        end else if (i_link_mtu > ihf_pkg::MTU_CEIL) begin
            mtu_c = ihf_pkg::MTU_CEIL;
        end else begin
            mtu_c = i_link_mtu;
        end
        maxpay = mtu_c - ihf_pkg::HDR_BYTES;
        fits   = r_plen <= {2'b00, maxpay};

        // header words that stay the same for every fragment of the packet
        base_sum = 19'(ihf_pkg::VER_IHL_WORD)
                 + 19'({ihf_pkg::TTL_VAL, r_proto})
                 + 19'(r_ident)
                 + 19'(i_src_addr[31:16]) + 19'(i_src_addr[15:0])
                 + 19'(r_dst[31:16]) + 19'(r_dst[15:0]);
        base_f1 = 17'(base_sum[15:0]) + 17'(base_sum[18:16]);
        base_f2 = base_f1[15:0] + 16'(base_f1[16]);

        o_push_data.payload_length = r_plen;
        o_push_data.dst            = r_dst;
        o_push_data.proto          = r_proto;
        o_push_data.ident          = r_ident;
        // a packet that fits goes out as one fragment of its whole length
        o_push_data.chunk          = fits ? r_plen[ihf_pkg::LEN_W-1:0]
                                          : {maxpay[ihf_pkg::LEN_W-1:ihf_pkg::FRAG_UNIT_LOG2],
                                             {ihf_pkg::FRAG_UNIT_LOG2{1'b0}}};
        o_push_data.csum_base      = base_f2;
    end

endmodule

`default_nettype wire

### sv/ihf_queue.sv
// Short descriptor queue between front and back, so each side stalls alone.
// Uses ihf_pkg.
`default_nettype none

module ihf_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire ihf_pkg::t_pkt_desc i_push_data,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_vld,
    output ihf_pkg::t_pkt_desc      o_head
);

    ihf_pkg::t_pkt_desc              r_mem [ihf_pkg::QDEPTH];
    logic [ihf_pkg::QPTR_W-1:0]      r_wptr;
    logic [ihf_pkg::QPTR_W-1:0]      r_rptr;
    logic [ihf_pkg::QCNT_W-1:0]      r_cnt;

    assign o_full = r_cnt == ihf_pkg::QCNT_W'(ihf_pkg::QDEPTH);
    assign o_vld  = r_cnt != '0;
    assign o_head = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == ihf_pkg::QPTR_W'(ihf_pkg::QDEPTH - 1))
                        ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == ihf_pkg::QPTR_W'(ihf_pkg::QDEPTH - 1))
                        ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### sv/ihf_back.sv
// Back end: walks one packet descriptor fragment by fragment and emits one
// header descriptor item per fragment through an output register. Uses ihf_pkg.
`default_nettype none

module ihf_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_vld,
    input  wire ihf_pkg::t_pkt_desc i_q_data,
    output logic                    o_pop,
    ihf_out_if.source               o_frag
);

    logic                          r_busy;
    ihf_pkg::t_pkt_desc            r_cur;
    logic [ihf_pkg::PLEN_W-1:0]    r_sent;

    logic                          r_out_vld;
    logic [ihf_pkg::LEN_W-1:0]     r_dlen;
    logic [ihf_pkg::ID_W-1:0]      r_ident;
    logic [ihf_pkg::FO_W-1:0]      r_fo;
    logic [ihf_pkg::CSUM_W-1:0]    r_csum;
    logic [ihf_pkg::ADDR_W-1:0]    r_dst;
    logic [ihf_pkg::PROTO_W-1:0]   r_proto;
    logic [ihf_pkg::PLEN_W-1:0]    r_off;
    logic [ihf_pkg::LEN_W-1:0]     r_flen;
    logic                          r_last;

    logic                          adv;
    logic [ihf_pkg::PLEN_W-1:0]    rem;
    logic                          last;
    logic [ihf_pkg::LEN_W-1:0]     flen;
    logic [ihf_pkg::FO_W-1:0]      fo;
    logic [ihf_pkg::LEN_W-1:0]     tot;
    logic [17:0]                   sum;
    logic [16:0]                   sum_f1;
    logic [15:0]                   sum_f2;

    always_comb begin
        rem    = r_cur.payload_length - r_sent;
        last   = rem <= {2'b00, r_cur.chunk};
        flen   = last ? rem[ihf_pkg::LEN_W-1:0] : r_cur.chunk;
        fo     = {!last, r_sent[ihf_pkg::PLEN_W-1:ihf_pkg::FRAG_UNIT_LOG2]};
        tot    = flen + ihf_pkg::HDR_BYTES;
        sum    = 18'(r_cur.csum_base) + 18'(tot) + 18'(fo);
        sum_f1 = 17'(sum[15:0]) + 17'(sum[17:16]);
        sum_f2 = sum_f1[15:0] + 16'(sum_f1[16]);
    end

    assign adv   = r_busy && (!r_out_vld || o_frag.ready);
    assign o_pop = i_q_vld && (!r_busy || (adv && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && last) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (o_frag.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_q_data;
            r_sent <= '0;
        end else if (adv) begin
            r_sent <= r_sent + 16'(flen);
        end
        if (adv) begin
            r_dlen  <= tot;
            r_ident <= r_cur.ident;
            r_fo    <= fo;
            r_csum  <= ~sum_f2;
            r_dst   <= r_cur.dst;
            r_proto <= r_cur.proto;
            r_off   <= r_sent;
            r_flen  <= flen;
            r_last  <= last;
        end
    end

    assign o_frag.valid            = r_out_vld;
    assign o_frag.datagram_length  = r_dlen;
    assign o_frag.identification   = r_ident;
    assign o_frag.flags_and_offset = r_fo;
    assign o_frag.header_checksum  = r_csum;
    assign o_frag.dest_out         = r_dst;
    assign o_frag.protocol_out     = r_proto;
    assign o_frag.payload_offset   = r_off;
    assign o_frag.fragment_length  = r_flen;
    assign o_frag.last_fragment    = r_last;

`ifndef SYNTHESIS
    a_offset_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !last && !o_pop) |=> (r_sent == $past(r_sent) + 16'($past(flen))))
        else $error("fragment offset did not advance by the fragment length");

    a_mf_matches_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_fo[ihf_pkg::FO_W-1] == !r_last))
        else $error("more-fragments bit disagrees with last marker");

    a_total_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_dlen == r_flen + ihf_pkg::HDR_BYTES))
        else $error("total length is not header plus fragment length");

    a_sent_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_sent <= r_cur.payload_length))
        else $error("fragment offset ran past the payload");
`endif

endmodule

`default_nettype wire

### sv/ipv4_header_fragmenter_core.sv
// IPv4 header fragmenter: packet items in on i_pkt, one header descriptor
// item per fragment out on o_frag, link MTU and source address set over APB.
//
// Use: present payload length, destination and protocol on i_pkt (valid/
// ready). Each accepted packet takes the next 16-bit identification. The
// block returns one descriptor per fragment on o_frag, in order of payload
// offset, with last_fragment set on the final one. Fragments other than the
// last carry (MTU - 20) rounded down to 8 bytes; the MTU is clamped to
// 1068..9216, so a packet gives at most 63 descriptors.
// Path: each packet passes the front's holding register, the descriptor
// queue, and the back end's current-packet and output registers. The back
// end emits one descriptor per cycle while o_frag.ready is high; the front
// accepts one packet per cycle until the 4-entry descriptor queue fills.
// Stalls: o_frag is registered; while o_frag.ready is low the descriptor
// holds, the back end waits and the queue keeps taking packets until full.
// Reset (synchronous, i_rst_n low) empties the queue, drops any packet in
// flight, clears the identification counter and restores MTU 1500 and source
// 192.168.100.80. Registers: 0x0 link_mtu, 0x4 source_address.
`default_nettype none

module ipv4_header_fragmenter_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    ihf_in_if.sink                           i_pkt,
    ihf_out_if.source                        o_frag,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ihf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [ihf_pkg::PDATA_W-1:0] pwdata,
    output logic      [ihf_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);

    logic [ihf_pkg::LEN_W-1:0]   r_link_mtu;
    logic [ihf_pkg::ADDR_W-1:0]  r_src_addr;

    logic                        cfg_wr;
    logic                        q_full;
    logic                        q_vld;
    logic                        push;
    logic                        pop;
    ihf_pkg::t_pkt_desc          push_data;
    ihf_pkg::t_pkt_desc          q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_mtu <= ihf_pkg::MTU_RESET;
            r_src_addr <= ihf_pkg::SRC_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                ihf_pkg::REG_LINK_MTU: r_link_mtu <= pwdata[ihf_pkg::LEN_W-1:0];
                ihf_pkg::REG_SRC_ADDR: r_src_addr <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ihf_pkg::REG_LINK_MTU: prdata = ihf_pkg::PDATA_W'(r_link_mtu);
            ihf_pkg::REG_SRC_ADDR: prdata = r_src_addr;
            default:               prdata = '0;
        endcase
    end

    ihf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt       (i_pkt),
        .i_link_mtu  (r_link_mtu),
        .i_src_addr  (r_src_addr),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    ihf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_vld       (q_vld),
        .o_head      (q_head)
    );

    ihf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (q_vld),
        .i_q_data (q_head),
        .o_pop    (pop),
        .o_frag   (o_frag)
    );

endmodule

`default_nettype wire
